// ===== rtl/psd_pkg.sv =====
// shared constants and codes for the point-to-segment distance core
// no dependencies
package psd_pkg;

    localparam int COORD_WIDTH_DEF = 32;

    // which part of the segment is closest to the query point
    typedef enum logic [1:0] {
        RGN_ON     = 2'd0,
        RGN_BEFORE = 2'd1,
        RGN_PAST   = 2'd2,
        RGN_POINT  = 2'd3
    } region_t;

endpackage

// ===== rtl/psd_root_step.sv =====
// one bit of the square-root-of-ratio recurrence: largest q with q*q*den <= num
// no dependencies, instantiated once per result bit by the top level
module psd_root_step #(
    parameter int XW  = 136,
    parameter int OW  = 33,
    parameter int BIT = 0
) (
    input  logic [XW-1:0] rem,
    input  logic [XW-1:0] acc,
    input  logic [XW-1:0] den,
    input  logic [OW-1:0] quo,
    output logic [XW-1:0] new_rem,
    output logic [XW-1:0] new_acc,
    output logic [OW-1:0] new_quo
);

    logic [XW-1:0] step;
    logic [XW-1:0] test;
    logic [OW-1:0] bit_mask;
    logic          take;

    // acc holds q*den, so (q+2^b)^2*den - q^2*den = ((2*acc) + den*2^b) * 2^b
    always_comb
    begin
        step     = den << BIT;
        test     = ((acc << 1) + step) << BIT;
        bit_mask = {{(OW-1){1'b0}}, 1'b1} << BIT;
        take     = (rem >= test);
        new_rem  = take ? (rem - test) : rem;
        new_acc  = take ? (acc + step) : acc;
        new_quo  = take ? (quo | bit_mask) : quo;
    end

endmodule

// ===== rtl/point_to_segment_distance_core.sv =====
// point-to-segment distance core: difference, product, sum, select, square stages
// then one pipeline stage per result bit of the root; uses psd_pkg and psd_root_step
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+------------------------------------------------
//  request | req_valid | req_stall | point_x/y, start_x/y, end_x/y (signed)
//  result  | rsp_valid | rsp_stall | seg_distance (unsigned), region
//
// one transaction per cycle while rsp_stall is low; the root recurrence resolves
// one result bit per stage.
// rst_n clears the stage valid bits only; data registers are not reset.
// each stage holds while the one after it is full and stalled, so bubbles are
// squeezed out and req_stall rises only when every stage holds a transaction.
module point_to_segment_distance_core #(
    parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] start_x,
    input  logic signed [COORD_WIDTH-1:0] start_y,
    input  logic signed [COORD_WIDTH-1:0] end_x,
    input  logic signed [COORD_WIDTH-1:0] end_y,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [COORD_WIDTH:0]          seg_distance,
    output logic [1:0]                    region
);

    import psd_pkg::*;

    localparam int DW = COORD_WIDTH + 1;     // coordinate difference
    localparam int PW = 2 * DW;              // product of two differences
    localparam int SW = PW + 1;              // sum of two products
    localparam int HW = (SW + 1) / 2;        // low half of a split operand
    localparam int HI = SW - HW;             // high half
    localparam int NW = 2 * SW;              // squared numerator
    localparam int XW = NW + 2;              // root recurrence working width
    localparam int OW = COORD_WIDTH + 1;     // result
    localparam int FS = 6;                   // stages ahead of the root
    localparam int NS = FS + OW;

    logic [NS-1:0] v_reg;
    logic [NS:0]   rdy;

    // stage 1: differences
    logic signed [DW-1:0] dx_reg, dy_reg, wx_reg, wy_reg, fx_reg, fy_reg;
    // stage 2: products
    logic signed [PW-1:0] lenx_reg, leny_reg, dotx_reg, doty_reg, crx_reg, cry_reg;
    logic signed [PW-1:0] nwx_reg, nwy_reg, nfx_reg, nfy_reg;
    logic                 degen2_reg;
    // stage 3: sums
    logic signed [SW-1:0] len_reg, dot_reg, cr_reg, nw_reg, nf_reg;
    logic                 degen3_reg;
    // stage 4: case selection
    region_t              rgn4_reg;
    logic [SW-1:0]        mag4_reg, den4_reg;
    // stage 5: partial squares of the cross product
    region_t              rgn5_reg;
    logic [SW-1:0]        mag5_reg, den5_reg;
    logic [2*HI-1:0]      hh_reg;
    logic [HI+HW-1:0]     hl_reg;
    logic [2*HW-1:0]      ll_reg;
    // stage 6: numerator
    region_t              rgn6_reg;
    logic [NW-1:0]        num_reg;
    logic [SW-1:0]        den6_reg;
    // root stages
    logic [XW-1:0]        rem_reg [OW];
    logic [XW-1:0]        acc_reg [OW];
    logic [XW-1:0]        rden_reg [OW];
    logic [OW-1:0]        quo_reg [OW];
    region_t              rrgn_reg [OW];

    // a stage may load when it is empty or its successor is loading
    assign rdy[NS] = !rsp_stall;
    genvar k;
    generate
        for (k = 0; k < NS; k++)
        begin : g_rdy
            assign rdy[k] = !v_reg[k] || rdy[k+1];
        end
    endgenerate

    assign req_stall = !rdy[0];
    assign rsp_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= (i == 0) ? req_valid : v_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    // stage 1
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            dx_reg <= $signed({end_x[COORD_WIDTH-1], end_x}) -
                      $signed({start_x[COORD_WIDTH-1], start_x});
            dy_reg <= $signed({end_y[COORD_WIDTH-1], end_y}) -
                      $signed({start_y[COORD_WIDTH-1], start_y});
            wx_reg <= $signed({point_x[COORD_WIDTH-1], point_x}) -
                      $signed({start_x[COORD_WIDTH-1], start_x});
            wy_reg <= $signed({point_y[COORD_WIDTH-1], point_y}) -
                      $signed({start_y[COORD_WIDTH-1], start_y});
            fx_reg <= $signed({point_x[COORD_WIDTH-1], point_x}) -
                      $signed({end_x[COORD_WIDTH-1], end_x});
            fy_reg <= $signed({point_y[COORD_WIDTH-1], point_y}) -
                      $signed({end_y[COORD_WIDTH-1], end_y});
        end
    end

    // stage 2
    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            lenx_reg   <= dx_reg * dx_reg;
            leny_reg   <= dy_reg * dy_reg;
            dotx_reg   <= wx_reg * dx_reg;
            doty_reg   <= wy_reg * dy_reg;
            crx_reg    <= wx_reg * dy_reg;
            cry_reg    <= wy_reg * dx_reg;
            nwx_reg    <= wx_reg * wx_reg;
            nwy_reg    <= wy_reg * wy_reg;
            nfx_reg    <= fx_reg * fx_reg;
            nfy_reg    <= fy_reg * fy_reg;
            degen2_reg <= (dx_reg == '0) && (dy_reg == '0);
        end
    end

    // stage 3
    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            len_reg    <= $signed({lenx_reg[PW-1], lenx_reg}) +
                          $signed({leny_reg[PW-1], leny_reg});
            dot_reg    <= $signed({dotx_reg[PW-1], dotx_reg}) +
                          $signed({doty_reg[PW-1], doty_reg});
            cr_reg     <= $signed({crx_reg[PW-1], crx_reg}) -
                          $signed({cry_reg[PW-1], cry_reg});
            nw_reg     <= $signed({nwx_reg[PW-1], nwx_reg}) +
                          $signed({nwy_reg[PW-1], nwy_reg});
            nf_reg     <= $signed({nfx_reg[PW-1], nfx_reg}) +
                          $signed({nfy_reg[PW-1], nfy_reg});
            degen3_reg <= degen2_reg;
        end
    end

    // stage 4
    region_t       rgn4_next;
    logic [SW-1:0] mag4_next, den4_next;
    always_comb
    begin
        den4_next = {{(SW-1){1'b0}}, 1'b1};
        priority if (degen3_reg)
        begin
            rgn4_next = RGN_POINT;
            mag4_next = nw_reg;
        end
        else if (dot_reg[SW-1])
        begin
            rgn4_next = RGN_BEFORE;
            mag4_next = nw_reg;
        end
        else if (len_reg < dot_reg)
        begin
            rgn4_next = RGN_PAST;
            mag4_next = nf_reg;
        end
        else
        begin
            rgn4_next = RGN_ON;
            mag4_next = cr_reg[SW-1] ? -cr_reg : cr_reg;
            den4_next = len_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            rgn4_reg <= rgn4_next;
            mag4_reg <= mag4_next;
            den4_reg <= den4_next;
        end
    end

    // stage 5: cross product is squared in split halves
    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            rgn5_reg <= rgn4_reg;
            mag5_reg <= mag4_reg;
            den5_reg <= den4_reg;
            hh_reg   <= mag4_reg[SW-1:HW] * mag4_reg[SW-1:HW];
            hl_reg   <= mag4_reg[SW-1:HW] * mag4_reg[HW-1:0];
            ll_reg   <= mag4_reg[HW-1:0] * mag4_reg[HW-1:0];
        end
    end

    // stage 6
    logic [NW-1:0] num6_next;
    always_comb
    begin
        if (rgn5_reg == RGN_ON)
        begin
            num6_next = ({{(NW-2*HI){1'b0}}, hh_reg} << (2 * HW)) +
                        ({{(NW-HI-HW){1'b0}}, hl_reg} << (HW + 1)) +
                        {{(NW-2*HW){1'b0}}, ll_reg};
        end
        else
        begin
            num6_next = {{(NW-SW){1'b0}}, mag5_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            rgn6_reg <= rgn5_reg;
            num_reg  <= num6_next;
            den6_reg <= den5_reg;
        end
    end

    // root stages, most significant result bit first
    genvar j;
    generate
        for (j = 0; j < OW; j++)
        begin : g_root
            logic [XW-1:0] rem_in, acc_in, den_in;
            logic [OW-1:0] quo_in;
            region_t       rgn_in;
            logic [XW-1:0] rem_nx, acc_nx;
            logic [OW-1:0] quo_nx;

            if (j == 0)
            begin : g_first
                assign rem_in = {2'b00, num_reg};
                assign acc_in = '0;
                assign den_in = {{(XW-SW){1'b0}}, den6_reg};
                assign quo_in = '0;
                assign rgn_in = rgn6_reg;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[j-1];
                assign acc_in = acc_reg[j-1];
                assign den_in = rden_reg[j-1];
                assign quo_in = quo_reg[j-1];
                assign rgn_in = rrgn_reg[j-1];
            end

            psd_root_step #(
                .XW  (XW),
                .OW  (OW),
                .BIT (OW - 1 - j)
            ) u_step (
                .rem     (rem_in),
                .acc     (acc_in),
                .den     (den_in),
                .quo     (quo_in),
                .new_rem (rem_nx),
                .new_acc (acc_nx),
                .new_quo (quo_nx)
            );

            always_ff @(posedge clk)
            begin
                if (rdy[FS+j])
                begin
                    rem_reg[j]  <= rem_nx;
                    acc_reg[j]  <= acc_nx;
                    rden_reg[j] <= den_in;
                    quo_reg[j]  <= quo_nx;
                    rrgn_reg[j] <= rgn_in;
                end
            end
        end
    endgenerate

    assign seg_distance = quo_reg[OW-1];
    assign region       = rrgn_reg[OW-1];

    // the request side stalls only with every stage occupied
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (&v_reg))
        else $error("request stalled with an empty stage");

    // a transaction taken in with none leaving adds one to the occupancy
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && !(rsp_valid && !rsp_stall))
        |=> ($countones(v_reg) == $past($countones(v_reg)) + 1))
        else $error("pipeline occupancy did not grow");

    // a transaction leaving with none taken in removes one
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (!(req_valid && !req_stall) && rsp_valid && !rsp_stall)
        |=> ($countones(v_reg) + 1 == $past($countones(v_reg))))
        else $error("pipeline occupancy did not shrink");

endmodule

// ===== tb/psd_checker.sv =====
// checker for the point-to-segment distance core: watches both channels,
// predicts each result with exact wide arithmetic and compares; uses psd_pkg
`timescale 1ns / 100ps

module psd_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_stall,
    input  logic signed [31:0]  point_x,
    input  logic signed [31:0]  point_y,
    input  logic signed [31:0]  start_x,
    input  logic signed [31:0]  start_y,
    input  logic signed [31:0]  end_x,
    input  logic signed [31:0]  end_y,
    input  logic                rsp_valid,
    input  logic                rsp_stall,
    input  logic [32:0]         seg_distance,
    input  logic [1:0]          region,
    output int                  fail_count,
    output int                  pending
);
    import psd_pkg::*;

    typedef struct {
        logic [32:0] distance;
        region_t     rgn;
    } seg_result_t;

    seg_result_t expected_results[$];

    // largest q with q*q*den <= num
    function automatic logic [32:0] floor_root_ratio(logic signed [199:0] num,
                                                     logic signed [199:0] den);
        logic [32:0] q;
        logic [32:0] cand;
        logic signed [199:0] lhs;
        q = '0;
        for (int b = 32; b >= 0; b--) begin
            cand = q | (33'd1 << b);
            lhs = $signed({167'd0, cand}) * $signed({167'd0, cand}) * den;
            if (lhs <= num)
                q = cand;
        end
        return q;
    endfunction

    function automatic seg_result_t closest_distance(
        logic signed [31:0] px, logic signed [31:0] py,
        logic signed [31:0] sx, logic signed [31:0] sy,
        logic signed [31:0] ex, logic signed [31:0] ey);
        logic signed [199:0] dx, dy, wx, wy, vx, vy, dot, len, cr, num, den;
        seg_result_t r;
        dx = 200'(ex) - 200'(sx);
        dy = 200'(ey) - 200'(sy);
        wx = 200'(px) - 200'(sx);
        wy = 200'(py) - 200'(sy);
        vx = 200'(px) - 200'(ex);
        vy = 200'(py) - 200'(ey);
        den = 1;
        if (dx == 0 && dy == 0) begin
            num = wx * wx + wy * wy;
            r.rgn = RGN_POINT;
        end
        else begin
            dot = wx * dx + wy * dy;
            len = dx * dx + dy * dy;
            if (dot < 0) begin
                num = wx * wx + wy * wy;
                r.rgn = RGN_BEFORE;
            end
            else if (dot > len) begin
                num = vx * vx + vy * vy;
                r.rgn = RGN_PAST;
            end
            else begin
                cr = wx * dy - wy * dx;
                num = cr * cr;
                den = len;
                r.rgn = RGN_ON;
            end
        end
        r.distance = floor_root_ratio(num, den);
        return r;
    endfunction

    assign pending = expected_results.size();

    initial fail_count = 0;

    always @(posedge clk) begin
        seg_result_t want;
        if (rst_n) begin
            if (req_valid && !req_stall)
                expected_results.push_back(closest_distance(point_x, point_y,
                    start_x, start_y, end_x, end_y));
            if (rsp_valid && !rsp_stall) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction");
                    fail_count++;
                end
                else begin
                    want = expected_results.pop_front();
                    if (seg_distance !== want.distance) begin
                        $error("seg_distance: expected %0d, got %0d", want.distance,
                               seg_distance);
                        fail_count++;
                    end
                    if (region !== want.rgn) begin
                        $error("region: expected %0d, got %0d", want.rgn, region);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/tb_top.sv =====
// testbench top for point_to_segment_distance_core: clock, reset, stimulus and verdict
// depends on psd_pkg, the core and psd_checker
`timescale 1ns / 100ps

module tb_top;
    import psd_pkg::*;

    localparam int LATENCY = 39;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk, rst_n;
    logic req_valid, req_stall, rsp_valid, rsp_stall;
    logic signed [31:0] point_x, point_y, start_x, start_y, end_x, end_y;
    logic [32:0] seg_distance;
    logic [1:0] region;
    int fail_count, pending;
    int send_idle_pct, recv_stall_pct;
    int idle_cycles;
    logic [31:0] item_vals [6];

    point_to_segment_distance_core DUT (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall),
        .point_x(point_x), .point_y(point_y),
        .start_x(start_x), .start_y(start_y),
        .end_x(end_x), .end_y(end_y),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .seg_distance(seg_distance), .region(region)
    );

    psd_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall),
        .point_x(point_x), .point_y(point_y),
        .start_x(start_x), .start_y(start_y),
        .end_x(end_x), .end_y(end_y),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .seg_distance(seg_distance), .region(region),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rsp_stall = 0;
    end

    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < recv_stall_pct);

    // watchdog: cycles with no accepted transaction on either side
    always @(posedge clk) begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic [31:0] pick_coord(int mode);
        case (mode)
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
            3: return 32'($signed($urandom_range(64)) - 32);
            default: return $urandom;
        endcase
    endfunction

    // one transaction; valid held until accepted, then optional gaps
    task automatic send_segment(logic [31:0] v [6]);
        point_x <= v[0]; point_y <= v[1];
        start_x <= v[2]; start_y <= v[3];
        end_x <= v[4]; end_y <= v[5];
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
    endtask

    task automatic send_coords(int px, int py, int sx, int sy, int ex, int ey);
        logic [31:0] v [6];
        v = '{px, py, sx, sy, ex, ey};
        send_segment(v);
    endtask

    initial begin
        int mode;
        int dx, dy;
        req_valid = 0;
        point_x = 0; point_y = 0; start_x = 0; start_y = 0; end_x = 0; end_y = 0;
        idle_cycles = 0;
        rst_n = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: degenerate, before, past, ends, on segment, extremes
        send_coords(32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0);
        send_coords(-65536, 0, 0, 0, 32'h000a_0000, 0);
        send_coords(32'h000c_0000, 32'h0001_0000, 0, 0, 32'h000a_0000, 0);
        send_coords(0, 32'h0005_0000, 0, 0, 32'h000a_0000, 0);
        send_coords(32'h000a_0000, 32'h0005_0000, 0, 0, 32'h000a_0000, 0);
        send_coords(32'h0005_0000, 32'h0003_0000, 0, 0, 32'h000a_0000, 0);
        send_coords(3, 7, 1, 1, 9, 5);
        send_coords(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                    32'h7fff_ffff, 32'h7fff_ffff);
        send_coords(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                    32'h8000_0000, 32'h7fff_ffff);
        send_coords(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                    32'h8000_0000, 32'h7fff_ffff);
        send_coords(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                    32'h7fff_ffff, 32'h7fff_ffff);
        send_coords(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                    32'h7fff_ffff, 32'h8000_0000);
        send_coords(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                    32'hffff_ffff, 32'hffff_ffff);
        send_coords(5, 5, 0, 0, 1, 1);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 75; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 75; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            for (int n = 0; n < 110; n++) begin
                mode = $urandom_range(9);
                for (int k = 0; k < 6; k++)
                    item_vals[k] = pick_coord(mode < 2 ? $urandom_range(4) :
                                              (mode < 6 ? 2 : (mode < 8 ? 3 : 4)));
                // some degenerate segments and points near the end points
                if ($urandom_range(9) == 0) begin
                    item_vals[4] = item_vals[2];
                    item_vals[5] = item_vals[3];
                end
                else if ($urandom_range(9) == 0) begin
                    dx = $signed($urandom_range(4)) - 2;
                    dy = $signed($urandom_range(4)) - 2;
                    item_vals[0] = item_vals[$urandom_range(1) ? 2 : 4] + dx;
                    item_vals[1] = item_vals[$urandom_range(1) ? 3 : 5] + dy;
                end
                send_segment(item_vals);
            end
            req_valid <= 1'b0;
            @(posedge clk);
        end

        while (pending != 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
